/* rtl/fcsg_pkg.sv */
// ----------------------------------------------------------------------------
// fcsg_pkg: shared definitions for the filled circle span generator
// Field widths, register indexes, reset values, controller states and the
// command and status records between controller and datapath.
// ----------------------------------------------------------------------------
package fcsg_pkg;

	// Field widths of the command and span channels.
	localparam int COORD_W = 13;
	localparam int RAD_W   = 7;
	localparam int COLOR_W = 32;
	localparam int ROW_W   = 12;
	localparam int MASK_W  = 4;

	// Configuration port.
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;
	localparam logic [CFG_W-1:0] DEF_SCREEN_WIDTH  = 13'd640;
	localparam logic [CFG_W-1:0] DEF_SCREEN_HEIGHT = 13'd480;

	// Default limits.
	localparam int DEF_MAX_RADIUS = 63;
	localparam int DEF_MAX_DIM    = 4096;
	localparam int RESULT_LIMIT   = 46;

	// Midpoint decision terms.
	localparam int D_INIT = 3;
	localparam int D_DIAG = 10;
	localparam int D_AXIS = 6;

	// Span valid bit positions.
	localparam int V_NARROW_TOP = 0;
	localparam int V_NARROW_BOT = 1;
	localparam int V_WIDE_TOP   = 2;
	localparam int V_WIDE_BOT   = 3;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic step;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic rad_neg;
		logic last;
		logic out_valid;
	} dp_sts_t;

	// One result.
	typedef struct packed {
		logic [ROW_W-1:0]   narrow_top_row;
		logic [ROW_W-1:0]   narrow_bottom_row;
		logic [ROW_W-1:0]   narrow_left;
		logic [ROW_W-1:0]   narrow_right;
		logic [ROW_W-1:0]   wide_top_row;
		logic [ROW_W-1:0]   wide_bottom_row;
		logic [ROW_W-1:0]   wide_left;
		logic [ROW_W-1:0]   wide_right;
		logic [MASK_W-1:0]  span_valid;
		logic [COLOR_W-1:0] span_color;
		logic               last_step;
	} span_t;

endpackage

/* rtl/fcsg_cmd_if.sv */
// ----------------------------------------------------------------------------
// fcsg_cmd_if: circle command channel
// Valid/ready channel that carries one circle command per transfer.
// ----------------------------------------------------------------------------
interface fcsg_cmd_if;
	logic                                valid;
	logic                                ready;
	logic signed [fcsg_pkg::COORD_W-1:0] center_x;
	logic signed [fcsg_pkg::COORD_W-1:0] center_y;
	logic signed [fcsg_pkg::RAD_W-1:0]   radius;
	logic [fcsg_pkg::COLOR_W-1:0]        fill_color;

	modport source (output valid, output center_x, output center_y, output radius,
		output fill_color, input ready);
	modport sink (input valid, input center_x, input center_y, input radius,
		input fill_color, output ready);
endinterface

/* rtl/fcsg_span_if.sv */
// ----------------------------------------------------------------------------
// fcsg_span_if: span result channel
// Valid/ready channel that carries the four spans of one iteration.
// ----------------------------------------------------------------------------
interface fcsg_span_if;
	logic                          valid;
	logic                          ready;
	logic [fcsg_pkg::ROW_W-1:0]    narrow_top_row;
	logic [fcsg_pkg::ROW_W-1:0]    narrow_bottom_row;
	logic [fcsg_pkg::ROW_W-1:0]    narrow_left;
	logic [fcsg_pkg::ROW_W-1:0]    narrow_right;
	logic [fcsg_pkg::ROW_W-1:0]    wide_top_row;
	logic [fcsg_pkg::ROW_W-1:0]    wide_bottom_row;
	logic [fcsg_pkg::ROW_W-1:0]    wide_left;
	logic [fcsg_pkg::ROW_W-1:0]    wide_right;
	logic [fcsg_pkg::MASK_W-1:0]   span_valid;
	logic [fcsg_pkg::COLOR_W-1:0]  span_color;
	logic                          last_step;

	modport source (output valid, output narrow_top_row, output narrow_bottom_row,
		output narrow_left, output narrow_right, output wide_top_row,
		output wide_bottom_row, output wide_left, output wide_right,
		output span_valid, output span_color, output last_step, input ready);
	modport sink (input valid, input narrow_top_row, input narrow_bottom_row,
		input narrow_left, input narrow_right, input wide_top_row,
		input wide_bottom_row, input wide_left, input wide_right,
		input span_valid, input span_color, input last_step, output ready);
endinterface

/* rtl/filled_circle_span_generator.sv */
// ----------------------------------------------------------------------------
// filled_circle_span_generator: filled circle span generator
// Runs the midpoint circle loop per command and emits four clipped
// horizontal spans per iteration.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   handshake
//  cmd      in   center_x, center_y, radius, fill_color    valid/ready
//  span     out  four spans, span_valid, color, last_step  valid/ready
//  cfg      in   cfg_index, cfg_data                       cfg_we strobe
//
//  A command is loaded, then the loop steps once per cycle while the result
//  register is free, giving one result per step; a circle of radius r gives
//  about r/sqrt(2)+1 results, at most 46, set by RESULT_LIMIT.
//  A negative radius is taken and gives no result.
//  Reset clears the sequencer and the result valid flag and sets the screen
//  size to 640 by 480. A stalled result holds the loop; the next command is
//  taken while the final result still waits.
// ----------------------------------------------------------------------------
module filled_circle_span_generator #(
	parameter int MAX_RADIUS = fcsg_pkg::DEF_MAX_RADIUS,
	parameter int MAX_DIM    = fcsg_pkg::DEF_MAX_DIM
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fcsg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fcsg_pkg::CFG_W-1:0]     cfg_data,
	fcsg_cmd_if.sink                       cmd,
	fcsg_span_if.source                    span
);

	fcsg_pkg::dp_cmd_t dp_cmd;
	fcsg_pkg::dp_sts_t dp_sts;
	fcsg_pkg::span_t   span_q;

	// Sequencer.
	fcsg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.out_ready (span.ready),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	// Datapath.
	fcsg_dp #(
		.MAX_RADIUS (MAX_RADIUS),
		.MAX_DIM    (MAX_DIM)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_center_x (cmd.center_x),
		.in_center_y (cmd.center_y),
		.in_radius   (cmd.radius),
		.in_color    (cmd.fill_color),
		.cmd         (dp_cmd),
		.sts         (dp_sts),
		.out_ready   (span.ready),
		.out_valid   (span.valid),
		.out_span    (span_q)
	);

	// Result fields onto the span channel.
	assign span.narrow_top_row    = span_q.narrow_top_row;
	assign span.narrow_bottom_row = span_q.narrow_bottom_row;
	assign span.narrow_left       = span_q.narrow_left;
	assign span.narrow_right      = span_q.narrow_right;
	assign span.wide_top_row      = span_q.wide_top_row;
	assign span.wide_bottom_row   = span_q.wide_bottom_row;
	assign span.wide_left         = span_q.wide_left;
	assign span.wide_right        = span_q.wide_right;
	assign span.span_valid        = span_q.span_valid;
	assign span.span_color        = span_q.span_color;
	assign span.last_step         = span_q.last_step;

endmodule

/* rtl/fcsg_ctrl.sv */
// ----------------------------------------------------------------------------
// fcsg_ctrl: command sequencer
// Accepts a command, then steps the datapath once per free output slot
// until the datapath reports the final iteration.
// ----------------------------------------------------------------------------
module fcsg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                out_ready,
	input  fcsg_pkg::dp_sts_t   sts,
	output fcsg_pkg::dp_cmd_t   cmd
);

	fcsg_pkg::state_t state_q;
	fcsg_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcsg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			fcsg_pkg::ST_IDLE: begin
				if (in_valid && !sts.rad_neg) begin
					state_d = fcsg_pkg::ST_RUN;
				end
			end
			fcsg_pkg::ST_RUN: begin
				if (cmd.step && sts.last) begin
					state_d = fcsg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fcsg_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs. A command with a negative radius is taken and dropped.
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			fcsg_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid && !sts.rad_neg;
			end
			fcsg_pkg::ST_RUN: begin
				cmd.step = !sts.out_valid || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/fcsg_dp.sv */
// ----------------------------------------------------------------------------
// fcsg_dp: circle iteration datapath
// Holds the screen size, the midpoint decision state of the current circle,
// the span clipping logic and the result register.
// ----------------------------------------------------------------------------
module fcsg_dp #(
	parameter int MAX_RADIUS = fcsg_pkg::DEF_MAX_RADIUS,
	parameter int MAX_DIM    = fcsg_pkg::DEF_MAX_DIM
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fcsg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fcsg_pkg::CFG_W-1:0]          cfg_data,
	input  logic signed [fcsg_pkg::COORD_W-1:0] in_center_x,
	input  logic signed [fcsg_pkg::COORD_W-1:0] in_center_y,
	input  logic signed [fcsg_pkg::RAD_W-1:0]   in_radius,
	input  logic [fcsg_pkg::COLOR_W-1:0]        in_color,
	input  fcsg_pkg::dp_cmd_t                   cmd,
	output fcsg_pkg::dp_sts_t                   sts,
	input  logic                                out_ready,
	output logic                                out_valid,
	output fcsg_pkg::span_t                     out_span
);

	localparam int ROW_W = fcsg_pkg::ROW_W;
	localparam int XW    = $clog2(MAX_RADIUS + 2);
	localparam int PW    = XW + 1;
	localparam int DW    = XW + 4;
	localparam int DIMW  = $clog2(MAX_DIM) + 1;
	localparam int CW    = ((fcsg_pkg::COORD_W > DIMW) ? fcsg_pkg::COORD_W : DIMW) + 2;
	localparam int SW    = ((fcsg_pkg::RAD_W > PW) ? fcsg_pkg::RAD_W : PW) + 1;
	localparam int NW    = $clog2(fcsg_pkg::RESULT_LIMIT + 1);
	localparam logic [CW-1:0] DIM_C  = CW'(MAX_DIM);
	localparam logic signed [SW-1:0] MAXR_C = SW'(MAX_RADIUS);
	localparam logic [NW-1:0] LIMIT_C = NW'(fcsg_pkg::RESULT_LIMIT);

	typedef struct packed {
		logic             ok;
		logic [ROW_W-1:0] l;
		logic [ROW_W-1:0] r;
	} clip_t;

	// Clip columns a..b to 0..w-1.
	function automatic clip_t clip_cols(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b, input logic signed [CW-1:0] w);
		clip_t c;
		logic signed [CW-1:0] lo;
		logic signed [CW-1:0] hi;
		c  = '0;
		lo = (a < 0) ? '0 : a;
		hi = (b > w - CW'(1)) ? w - CW'(1) : b;
		if (!(b < 0 || a >= w)) begin
			c.ok = 1'b1;
			c.l  = lo[ROW_W-1:0];
			c.r  = hi[ROW_W-1:0];
		end
		return c;
	endfunction

	// Row check; returns the valid flag above the row.
	function automatic logic [ROW_W:0] row_chk(input logic signed [CW-1:0] row,
			input logic cols, input logic signed [CW-1:0] h);
		logic [ROW_W:0] res;
		res = '0;
		if (cols && row >= 0 && row < h) begin
			res = {1'b1, row[ROW_W-1:0]};
		end
		return res;
	endfunction

	logic [fcsg_pkg::CFG_W-1:0]          width_q;
	logic [fcsg_pkg::CFG_W-1:0]          height_q;
	logic signed [fcsg_pkg::COORD_W-1:0] cx_q;
	logic signed [fcsg_pkg::COORD_W-1:0] cy_q;
	logic [fcsg_pkg::COLOR_W-1:0]        color_q;
	logic signed [PW-1:0]                x_q;
	logic signed [PW-1:0]                y_q;
	logic signed [DW-1:0]                d_q;
	logic [NW-1:0]                       n_q;
	logic                                out_valid_q;
	fcsg_pkg::span_t                     out_q;

	logic [CW-1:0]        w_ext, h_ext;
	logic signed [CW-1:0] w_s, h_s;
	logic signed [CW-1:0] xe, ye, cxe, cye;
	clip_t                nclip, wclip;
	logic [ROW_W:0]       nt, nb, wt, wb;
	logic signed [SW-1:0] r_ext, r_sat;
	logic signed [PW-1:0] y0;
	logic signed [DW-1:0] d0;
	logic signed [PW-1:0] x1, y1;
	logic signed [DW-1:0] d1;
	logic [NW-1:0]        n1;
	logic                 last;

	// Screen size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= fcsg_pkg::DEF_SCREEN_WIDTH;
			height_q <= fcsg_pkg::DEF_SCREEN_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_index)
				fcsg_pkg::REG_SCREEN_WIDTH:  width_q  <= cfg_data;
				fcsg_pkg::REG_SCREEN_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Screen size saturated to the largest supported dimension.
	always_comb begin
		w_ext = CW'(width_q);
		h_ext = CW'(height_q);
		w_s   = (w_ext > DIM_C) ? DIM_C : w_ext;
		h_s   = (h_ext > DIM_C) ? DIM_C : h_ext;
	end

	// Initial decision state from the command radius.
	always_comb begin
		r_ext = SW'(in_radius);
		r_sat = (r_ext > MAXR_C) ? MAXR_C : r_ext;
		y0    = PW'(r_sat);
		d0    = DW'(fcsg_pkg::D_INIT) - (DW'(y0) <<< 1);
	end

	// Span endpoints and clipping for the current iteration.
	always_comb begin
		xe    = CW'(x_q);
		ye    = CW'(y_q);
		cxe   = CW'(cx_q);
		cye   = CW'(cy_q);
		nclip = clip_cols(cxe - xe, cxe + xe, w_s);
		wclip = clip_cols(cxe - ye, cxe + ye, w_s);
		nt    = row_chk(cye - ye, nclip.ok, h_s);
		nb    = row_chk(cye + ye, nclip.ok, h_s);
		wt    = row_chk(cye - xe, wclip.ok, h_s);
		wb    = row_chk(cye + xe, wclip.ok, h_s);
	end

	// Midpoint update and end-of-circle test.
	always_comb begin
		x1 = x_q + PW'(1);
		if (d_q > 0) begin
			y1 = y_q - PW'(1);
			d1 = d_q + ((DW'(x1) - DW'(y1)) <<< 2) + DW'(fcsg_pkg::D_DIAG);
		end else begin
			y1 = y_q;
			d1 = d_q + (DW'(x1) <<< 2) + DW'(fcsg_pkg::D_AXIS);
		end
		n1   = n_q + NW'(1);
		last = (y1 < x1) || (n1 >= LIMIT_C);
	end

	// Iteration registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q    <= in_center_x;
			cy_q    <= in_center_y;
			color_q <= in_color;
			x_q     <= '0;
			y_q     <= y0;
			d_q     <= d0;
			n_q     <= '0;
		end else if (cmd.step) begin
			x_q <= x1;
			y_q <= y1;
			d_q <= d1;
			n_q <= n1;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			out_q.narrow_top_row    <= nt[ROW_W-1:0];
			out_q.narrow_bottom_row <= nb[ROW_W-1:0];
			out_q.narrow_left       <= nclip.l;
			out_q.narrow_right      <= nclip.r;
			out_q.wide_top_row      <= wt[ROW_W-1:0];
			out_q.wide_bottom_row   <= wb[ROW_W-1:0];
			out_q.wide_left         <= wclip.l;
			out_q.wide_right        <= wclip.r;
			out_q.span_valid        <= {wb[ROW_W], wt[ROW_W], nb[ROW_W], nt[ROW_W]};
			out_q.span_color        <= color_q;
			out_q.last_step         <= last;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.rad_neg   = in_radius[fcsg_pkg::RAD_W-1];
	assign sts.last      = last;
	assign sts.out_valid = out_valid_q;
	assign out_valid     = out_valid_q;
	assign out_span      = out_q;

`ifndef SYNTHESIS
	// Every step runs inside the loop condition.
	a_step_in_loop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (y_q >= x_q))
		else $error("step issued after the circle finished");

	// A step never overwrites a result that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

	// A valid narrow span has ordered columns.
	a_narrow_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.span_valid[fcsg_pkg::V_NARROW_TOP])
			|-> (out_q.narrow_left <= out_q.narrow_right))
		else $error("narrow span columns out of order");

	// An invalid wide top span reports row zero.
	a_wide_row_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.span_valid[fcsg_pkg::V_WIDE_TOP])
			|-> (out_q.wide_top_row == '0))
		else $error("invalid span with nonzero row");
`endif

endmodule

/* bench/filled_circle_span_generator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filled_circle_span_generator_test: self-checking bench for the span generator
// Drives circle commands through the command channel and predicts every span
// result with a behavioral midpoint circle loop in the bench. Results are
// compared field by field in arrival order. Both channels idle and stall at
// random, and the screen size is changed between phases while the block idles.
// ----------------------------------------------------------------------------
module filled_circle_span_generator_test;

	localparam int MAX_RADIUS    = fcsg_pkg::DEF_MAX_RADIUS;
	localparam int MAX_DIM       = fcsg_pkg::DEF_MAX_DIM;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 8;
	localparam int IDLE_LIMIT    = 2000;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_we;
	logic [fcsg_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [fcsg_pkg::CFG_W-1:0]       cfg_data;

	fcsg_cmd_if  cmd_ch ();
	fcsg_span_if span_ch ();

	filled_circle_span_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.span      (span_ch)
	);

	// Bench copy of the screen size registers.
	logic [fcsg_pkg::CFG_W-1:0] screen_w;
	logic [fcsg_pkg::CFG_W-1:0] screen_h;

	fcsg_pkg::span_t expected_spans[$];
	int    error_count = 0;
	int    commands_sent;
	int    spans_checked = 0;
	int    settings_applied;
	int    idle_cycles = 0;
	int    next_gap;
	bit    quiet;

	// Clock generation.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Gap length: mostly none, some short, a few long.
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	function automatic int screen_dim(logic [fcsg_pkg::CFG_W-1:0] v);
		return (v > MAX_DIM) ? MAX_DIM : int'(v);
	endfunction

	// Clip columns a..b to the screen; returns 1 when the range meets it.
	function automatic bit clip_columns(int a, int b, int w,
			output logic [fcsg_pkg::ROW_W-1:0] left,
			output logic [fcsg_pkg::ROW_W-1:0] right);
		if (b < 0 || a >= w) begin
			left  = '0;
			right = '0;
			return 1'b0;
		end
		if (a < 0)
			a = 0;
		if (b > w - 1)
			b = w - 1;
		left  = a[fcsg_pkg::ROW_W-1:0];
		right = b[fcsg_pkg::ROW_W-1:0];
		return 1'b1;
	endfunction

	// A row is shown when its pair meets the screen and the row is visible.
	function automatic bit place_row(int row, bit cols_ok, int h,
			output logic [fcsg_pkg::ROW_W-1:0] v);
		if (cols_ok && row >= 0 && row < h) begin
			v = row[fcsg_pkg::ROW_W-1:0];
			return 1'b1;
		end
		v = '0;
		return 1'b0;
	endfunction

	// Run the midpoint loop for one command and queue the spans it yields.
	task automatic trace_circle(logic signed [fcsg_pkg::COORD_W-1:0] cx_in,
			logic signed [fcsg_pkg::COORD_W-1:0] cy_in,
			logic signed [fcsg_pkg::RAD_W-1:0] rad_in,
			logic [fcsg_pkg::COLOR_W-1:0] color);
		int    cx, cy, rad, x, y, d, n, w, h;
		bit    nc, wc;
		fcsg_pkg::span_t s;
		cx = cx_in;
		cy = cy_in;
		rad = rad_in;
		w = screen_dim(screen_w);
		h = screen_dim(screen_h);
		if (rad < 0)
			return;
		if (rad > MAX_RADIUS)
			rad = MAX_RADIUS;
		x = 0;
		y = rad;
		d = fcsg_pkg::D_INIT - 2 * rad;
		n = 0;
		while (y >= x && n < fcsg_pkg::RESULT_LIMIT) begin
			s = '0;
			nc = clip_columns(cx - x, cx + x, w, s.narrow_left, s.narrow_right);
			wc = clip_columns(cx - y, cx + y, w, s.wide_left, s.wide_right);
			s.span_valid[fcsg_pkg::V_NARROW_TOP] =
				place_row(cy - y, nc, h, s.narrow_top_row);
			s.span_valid[fcsg_pkg::V_NARROW_BOT] =
				place_row(cy + y, nc, h, s.narrow_bottom_row);
			s.span_valid[fcsg_pkg::V_WIDE_TOP] =
				place_row(cy - x, wc, h, s.wide_top_row);
			s.span_valid[fcsg_pkg::V_WIDE_BOT] =
				place_row(cy + x, wc, h, s.wide_bottom_row);
			s.span_color = color;
			x++;
			if (d > 0) begin
				y--;
				d = d + 4 * (x - y) + fcsg_pkg::D_DIAG;
			end else begin
				d = d + 4 * x + fcsg_pkg::D_AXIS;
			end
			n++;
			s.last_step = (y < x || n >= fcsg_pkg::RESULT_LIMIT);
			expected_spans.push_back(s);
		end
	endtask

	// Send one command; valid stays high afterwards only when the next one follows at once.
	task automatic send_circle(logic signed [fcsg_pkg::COORD_W-1:0] cx,
			logic signed [fcsg_pkg::COORD_W-1:0] cy,
			logic signed [fcsg_pkg::RAD_W-1:0] rad,
			logic [fcsg_pkg::COLOR_W-1:0] color);
		if (next_gap != 0)
			repeat (next_gap) @(posedge clk);
		cmd_ch.valid      <= 1'b1;
		cmd_ch.center_x   <= cx;
		cmd_ch.center_y   <= cy;
		cmd_ch.radius     <= rad;
		cmd_ch.fill_color <= color;
		do
			@(posedge clk);
		while (cmd_ch.ready !== 1'b1);
		trace_circle(cx, cy, rad, color);
		commands_sent++;
		next_gap = pick_gap();
		if (next_gap != 0)
			cmd_ch.valid <= 1'b0;
	endtask

	// Drop valid in the step of the last transfer and let the block finish.
	task automatic drain_block();
		if (next_gap == 0) begin
			cmd_ch.valid <= 1'b0;
			next_gap = 1;
		end
		while (expected_spans.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both screen size registers while the block is idle.
	task automatic apply_screen(logic [fcsg_pkg::CFG_W-1:0] w,
			logic [fcsg_pkg::CFG_W-1:0] h);
		drain_block();
		cfg_we    <= 1'b1;
		cfg_index <= fcsg_pkg::REG_SCREEN_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= fcsg_pkg::REG_SCREEN_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_we   <= 1'b0;
		screen_w = w;
		screen_h = h;
		settings_applied++;
	endtask

	// Result side back-pressure.
	always @(posedge clk) begin
		static int hold_cnt = 0;
		int gap;
		if (hold_cnt != 0) begin
			hold_cnt--;
		end else begin
			gap = pick_gap();
			if (gap == 0) begin
				span_ch.ready <= 1'b1;
			end else begin
				span_ch.ready <= 1'b0;
				hold_cnt = gap - 1;
			end
		end
	end

	task automatic compare_field(string name, logic [fcsg_pkg::COLOR_W-1:0] want,
			logic [fcsg_pkg::COLOR_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
			error_count++;
		end
	endtask

	// Check every result transfer against the oldest expected span set.
	always @(posedge clk) begin
		fcsg_pkg::span_t want;
		if (arst_n && span_ch.valid === 1'b1 && span_ch.ready === 1'b1) begin
			if (expected_spans.size() == 0) begin
				$error("span result with no command outstanding");
				error_count++;
			end else begin
				want = expected_spans.pop_front();
				spans_checked++;
				compare_field("narrow_top_row", want.narrow_top_row, span_ch.narrow_top_row);
				compare_field("narrow_bottom_row", want.narrow_bottom_row,
					span_ch.narrow_bottom_row);
				compare_field("narrow_left", want.narrow_left, span_ch.narrow_left);
				compare_field("narrow_right", want.narrow_right, span_ch.narrow_right);
				compare_field("wide_top_row", want.wide_top_row, span_ch.wide_top_row);
				compare_field("wide_bottom_row", want.wide_bottom_row, span_ch.wide_bottom_row);
				compare_field("wide_left", want.wide_left, span_ch.wide_left);
				compare_field("wide_right", want.wide_right, span_ch.wide_right);
				compare_field("span_valid", want.span_valid, span_ch.span_valid);
				compare_field("span_color", want.span_color, span_ch.span_color);
				compare_field("last_step", want.last_step, span_ch.last_step);
			end
		end
	end

	// Watchdog: count cycles without any transfer.
	always @(posedge clk) begin
		if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
				(span_ch.valid === 1'b1 && span_ch.ready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("FAIL");
		$finish;
	end

	// Directed commands at the reset screen size of 640 by 480.
	task automatic test_default_screen();
		send_circle(13'sd320, 13'sd240, 7'sd0, 32'h0000_0000);
		send_circle(13'sd320, 13'sd240, 7'sd1, 32'hFFFF_FFFF);
		send_circle(13'sd320, 13'sd240, 7'sd63, 32'hA5A5_5A5A);
		send_circle(13'sd100, 13'sd100, -7'sd1, 32'h1234_5678);
		send_circle(13'sd100, 13'sd100, -7'sd64, 32'h8765_4321);
		send_circle(-13'sd4096, -13'sd4096, 7'sd63, 32'h5A5A_A5A5);
		send_circle(13'sd4095, 13'sd4095, 7'sd63, 32'hDEAD_BEEF);
		// Circles that straddle the screen corners and the left edge.
		send_circle(13'sd0, 13'sd0, 7'sd10, 32'h00FF_00FF);
		send_circle(13'sd639, 13'sd479, 7'sd5, 32'hFF00_FF00);
		send_circle(-13'sd20, 13'sd240, 7'sd25, 32'h0F0F_F0F0);
	endtask

	// One pixel screen: nearly every span clips down to a single column.
	task automatic test_tiny_screen();
		apply_screen(13'd1, 13'd1);
		send_circle(13'sd0, 13'sd0, 7'sd0, 32'h1111_1111);
		send_circle(13'sd0, 13'sd0, 7'sd3, 32'h2222_2222);
		send_circle(-13'sd1, 13'sd0, 7'sd1, 32'h3333_3333);
		send_circle(13'sd2, 13'sd2, 7'sd1, 32'h4444_4444);
	endtask

	// Zero size screen: every span is invalid.
	task automatic test_zero_screen();
		apply_screen(13'd0, 13'd0);
		send_circle(13'sd0, 13'sd0, 7'sd4, 32'h5555_5555);
		send_circle(13'sd10, -13'sd5, 7'sd20, 32'h6666_6666);
	endtask

	// Sizes beyond the maximum saturate; then the exact maximum.
	task automatic test_saturated_screen();
		apply_screen(13'd8191, 13'd8191);
		send_circle(13'sd4095, 13'sd4095, 7'sd63, 32'h7777_7777);
		send_circle(13'sd4070, 13'sd30, 7'sd40, 32'h8888_8888);
		apply_screen(13'd4096, 13'd4096);
		send_circle(13'sd4095, 13'sd0, 7'sd63, 32'h9999_9999);
		send_circle(13'sd2048, 13'sd4090, 7'sd12, 32'hAAAA_AAAA);
	endtask

	// Random commands at one screen setting; the first quiet_items run without idling.
	task automatic test_random_circles(int count, int quiet_items,
			logic [fcsg_pkg::CFG_W-1:0] w, logic [fcsg_pkg::CFG_W-1:0] h);
		int r, dw, dh;
		logic signed [fcsg_pkg::COORD_W-1:0] cx, cy;
		logic signed [fcsg_pkg::RAD_W-1:0]   rad;
		apply_screen(w, h);
		dw = screen_dim(w);
		dh = screen_dim(h);
		for (int i = 0; i < count; i++) begin
			quiet = (i < quiet_items);
			// Most centers sit near the screen so clipping gets exercised.
			if ($urandom_range(0, 3) != 0) begin
				cx = fcsg_pkg::COORD_W'(int'($urandom_range(0, dw + 160)) - 80);
				cy = fcsg_pkg::COORD_W'(int'($urandom_range(0, dh + 160)) - 80);
			end else begin
				cx = fcsg_pkg::COORD_W'($urandom());
				cy = fcsg_pkg::COORD_W'($urandom());
			end
			// Mostly small radii, some large, a few negative.
			r = $urandom_range(0, 99);
			if (r < 8)
				rad = fcsg_pkg::RAD_W'($urandom_range(64, 127));
			else if (r < 75)
				rad = fcsg_pkg::RAD_W'($urandom_range(0, 12));
			else if (r < 92)
				rad = fcsg_pkg::RAD_W'($urandom_range(13, 40));
			else
				rad = fcsg_pkg::RAD_W'($urandom_range(41, 63));
			send_circle(cx, cy, rad, $urandom());
		end
		quiet = 1'b0;
	endtask

	// Reset, then run the tests in turn.
	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = fcsg_pkg::REG_SCREEN_WIDTH;
		cfg_data         = '0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.center_x  = '0;
		cmd_ch.center_y  = '0;
		cmd_ch.radius    = '0;
		cmd_ch.fill_color = '0;
		screen_w         = fcsg_pkg::DEF_SCREEN_WIDTH;
		screen_h         = fcsg_pkg::DEF_SCREEN_HEIGHT;
		commands_sent    = 0;
		settings_applied = 0;
		next_gap         = 1;
		quiet            = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_screen();
		test_tiny_screen();
		test_zero_screen();
		test_saturated_screen();
		test_random_circles(60, 30, fcsg_pkg::DEF_SCREEN_WIDTH, fcsg_pkg::DEF_SCREEN_HEIGHT);
		test_random_circles(70, 0, fcsg_pkg::CFG_W'($urandom_range(1, 100)),
			fcsg_pkg::CFG_W'($urandom_range(1, 100)));
		test_random_circles(70, 0, fcsg_pkg::CFG_W'($urandom_range(1, 8191)),
			fcsg_pkg::CFG_W'($urandom_range(1, 8191)));
		test_random_circles(60, 0, 13'd4096, 13'd8191);
		test_random_circles(60, 0, 13'd1, 13'd4096);

		drain_block();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d circle commands giving %0d checked span results,",
			commands_sent, spans_checked);
		$display("over %0d screen size settings plus the reset size.", settings_applied);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
